// ===== design/qfct_pkg.sv =====
// Package with the shared types and constants of the flow-control credit tracker.
`timescale 1ns / 1ps

package qfct_pkg;

  // Default widths of byte counts and of round trip times.
  localparam int COUNT_BITS_DEF = 62;
  localparam int TIME_BITS_DEF  = 32;

  // Event selector carried on the input tuser.
  localparam int FUNC_BITS = 3;

  typedef enum logic [FUNC_BITS-1:0] {
    FUNC_INIT         = 3'd0,
    FUNC_CONSUME      = 3'd1,
    FUNC_RAISE_LIMIT  = 3'd2,
    FUNC_CHECK_BLOCK  = 3'd3,
    FUNC_RECORD_OFS   = 3'd4,
    FUNC_APP_READ     = 3'd5,
    FUNC_CHECK_UPDATE = 3'd6,
    FUNC_UPDATE_SENT  = 3'd7
  } func_t;

  // Configuration register indexes.
  localparam int CFG_INDEX_BITS = 8;
  localparam logic [CFG_INDEX_BITS-1:0] REG_START_CREDIT   = 8'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_CEILING = 8'd1;

  // Reset values of the configuration registers.
  localparam logic [63:0] START_CREDIT_RST   = 64'd65536;
  localparam logic [63:0] WINDOW_CEILING_RST = 64'd16777216;

endpackage

// ===== design/quic_flow_credit_tracker.sv =====
// Top level of the QUIC-style flow-control credit tracker.
`timescale 1ns / 1ps

// The tracker keeps one flow-control credit record and applies one event per
// input beat, selected by the func code on s_tuser: init, consume, raise
// limit, check blocked, record offset, application read (window auto-tuning),
// check update and update sent. Every input beat yields exactly one result
// beat carrying the accepted flag on m_tuser and the remaining credit and the
// proposed limit on m_tdata. An input beat is captured in an input register
// and, once the result register is free, its event is evaluated against
// the record and written to the result register, and in this way a new
// beat is taken every cycle as long as the result side keeps up; the record
// update is a single compare, add and select path, which sets the one beat
// per cycle figure. The input register empties into the result register
// while an earlier result is taken in the same cycle. Configuration writes
// are taken at any time (cfg_ready is always high) but only act at the next
// init event, which latches the start credit and the effective window
// ceiling, the larger of the ceiling register and the start credit.
module quic_flow_credit_tracker #(
  parameter int COUNT_BITS = qfct_pkg::COUNT_BITS_DEF,
  parameter int TIME_BITS  = qfct_pkg::TIME_BITS_DEF,
  localparam int IN_BITS   = ((COUNT_BITS + 2 * TIME_BITS + 7) / 8) * 8,
  localparam int OUT_BITS  = ((2 * COUNT_BITS + 7) / 8) * 8
) (
  input  logic                                clk,
  input  logic                                rst,
  // Configuration write channel.
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [qfct_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [COUNT_BITS-1:0]               cfg_data,
  // Event input.
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // From bit 0: amount, round_trip_us, drain_time_us, zero fill.
  input  logic [IN_BITS-1:0]                  s_tdata,
  // From bit 0: func.
  input  logic [qfct_pkg::FUNC_BITS-1:0]      s_tuser,
  // Result output.
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // From bit 0: credit_left, advertise_limit, zero fill.
  output logic [OUT_BITS-1:0]                 m_tdata,
  // From bit 0: accepted.
  output logic                                m_tuser
);

  localparam logic [COUNT_BITS-1:0] START_RST   = COUNT_BITS'(qfct_pkg::START_CREDIT_RST);
  localparam logic [COUNT_BITS-1:0] CEILING_RST = COUNT_BITS'(qfct_pkg::WINDOW_CEILING_RST);
  localparam logic [COUNT_BITS-1:0] CNT_ALL_ONES = '1;

  // Configuration registers.
  logic [COUNT_BITS-1:0] start_credit;
  logic [COUNT_BITS-1:0] window_ceiling;

  // Credit record.
  logic [COUNT_BITS-1:0] credit_limit, credit_limit_next;
  logic [COUNT_BITS-1:0] consumed_offset, consumed_offset_next;
  logic [COUNT_BITS-1:0] tuned_window, tuned_window_next;
  logic                  stall_reported, stall_reported_next;
  logic [COUNT_BITS-1:0] stall_limit, stall_limit_next;
  logic [COUNT_BITS-1:0] eff_ceiling, eff_ceiling_next;

  // Input register.
  logic                  in_valid;
  qfct_pkg::func_t       in_func;
  logic [COUNT_BITS-1:0] in_amount;
  logic [TIME_BITS-1:0]  in_rtt;
  logic [TIME_BITS-1:0]  in_drain;

  // Result register.
  logic                  res_accepted, res_accepted_next;
  logic [COUNT_BITS-1:0] res_credit, res_credit_next;
  logic [COUNT_BITS-1:0] res_adv, res_adv_next;

  logic                  advance;
  logic                  in_take;
  logic [COUNT_BITS-1:0] remaining;
  logic [COUNT_BITS:0]   consume_sum;
  logic [COUNT_BITS:0]   propose_sum;
  logic [COUNT_BITS-1:0] proposal;
  logic [TIME_BITS:0]    rtt_twice;

  assign cfg_ready = 1'b1;

  // The result register frees up when empty or being taken this cycle.
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !in_valid || advance;
  assign in_take  = s_tvalid && s_tready;

  assign m_tuser = res_accepted;
  assign m_tdata = {{(OUT_BITS - 2 * COUNT_BITS){1'b0}}, res_adv, res_credit};

  assign remaining   = (credit_limit > consumed_offset) ? credit_limit - consumed_offset : '0;
  assign consume_sum = {1'b0, consumed_offset} + {1'b0, in_amount};
  assign propose_sum = {1'b0, consumed_offset} + {1'b0, tuned_window};
  assign proposal    = propose_sum[COUNT_BITS] ? CNT_ALL_ONES : propose_sum[COUNT_BITS-1:0];
  assign rtt_twice   = {in_rtt, 1'b0};

  // Event evaluation against the current record.
  always_comb begin
    credit_limit_next    = credit_limit;
    consumed_offset_next = consumed_offset;
    tuned_window_next    = tuned_window;
    stall_reported_next  = stall_reported;
    stall_limit_next     = stall_limit;
    eff_ceiling_next     = eff_ceiling;
    res_accepted_next    = 1'b0;
    res_adv_next         = '0;
    case (in_func)
      qfct_pkg::FUNC_INIT: begin
        credit_limit_next    = start_credit;
        consumed_offset_next = '0;
        tuned_window_next    = start_credit;
        stall_reported_next  = 1'b0;
        stall_limit_next     = '0;
        eff_ceiling_next     = (window_ceiling < start_credit) ? start_credit : window_ceiling;
      end
      qfct_pkg::FUNC_CONSUME: begin
        // Saturates at the all-ones count.
        consumed_offset_next = consume_sum[COUNT_BITS] ? CNT_ALL_ONES
                                                       : consume_sum[COUNT_BITS-1:0];
      end
      qfct_pkg::FUNC_RAISE_LIMIT: begin
        if (in_amount > credit_limit) begin
          credit_limit_next   = in_amount;
          stall_reported_next = 1'b0;
          res_accepted_next   = 1'b1;
        end
      end
      qfct_pkg::FUNC_CHECK_BLOCK: begin
        // Blocked is reported once for each limit value.
        if (remaining == '0 && !(stall_reported && stall_limit == credit_limit)) begin
          stall_reported_next = 1'b1;
          stall_limit_next    = credit_limit;
          res_accepted_next   = 1'b1;
        end
      end
      qfct_pkg::FUNC_RECORD_OFS: begin
        if (in_amount <= consumed_offset) begin
          res_accepted_next = 1'b1;
        end else if (in_amount <= credit_limit) begin
          consumed_offset_next = in_amount;
          res_accepted_next    = 1'b1;
        end
      end
      qfct_pkg::FUNC_APP_READ: begin
        // Double the window when the peer drained it in under two round trips.
        if (in_rtt != '0 && in_drain != '0 && tuned_window < eff_ceiling &&
            {1'b0, in_drain} < rtt_twice) begin
          if (tuned_window > eff_ceiling - tuned_window) begin
            tuned_window_next = eff_ceiling;
          end else begin
            tuned_window_next = {tuned_window[COUNT_BITS-2:0], 1'b0};
          end
        end
      end
      qfct_pkg::FUNC_CHECK_UPDATE: begin
        if (remaining <= (tuned_window >> 1) && proposal > credit_limit) begin
          res_accepted_next = 1'b1;
          res_adv_next      = proposal;
        end
      end
      qfct_pkg::FUNC_UPDATE_SENT: begin
        if (in_amount > credit_limit) begin
          credit_limit_next = in_amount;
        end
      end
      default: begin
      end
    endcase
    res_credit_next = (credit_limit_next > consumed_offset_next)
                      ? credit_limit_next - consumed_offset_next : '0;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      start_credit   <= START_RST;
      window_ceiling <= CEILING_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == qfct_pkg::REG_START_CREDIT) begin
        start_credit <= cfg_data;
      end else if (cfg_index == qfct_pkg::REG_WINDOW_CEILING) begin
        window_ceiling <= cfg_data;
      end
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_take) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_func   <= qfct_pkg::func_t'(s_tuser);
      in_amount <= s_tdata[COUNT_BITS-1:0];
      in_rtt    <= s_tdata[COUNT_BITS +: TIME_BITS];
      in_drain  <= s_tdata[COUNT_BITS + TIME_BITS +: TIME_BITS];
    end
  end

  // Record and result update.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid        <= 1'b0;
      credit_limit    <= '0;
      consumed_offset <= '0;
      tuned_window    <= '0;
      stall_reported  <= 1'b0;
      stall_limit     <= '0;
      eff_ceiling     <= '0;
    end else if (advance) begin
      m_tvalid <= in_valid;
      if (in_valid) begin
        credit_limit    <= credit_limit_next;
        consumed_offset <= consumed_offset_next;
        tuned_window    <= tuned_window_next;
        stall_reported  <= stall_reported_next;
        stall_limit     <= stall_limit_next;
        eff_ceiling     <= eff_ceiling_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      res_accepted <= res_accepted_next;
      res_credit   <= res_credit_next;
      res_adv      <= res_adv_next;
    end
  end

endmodule

// ===== design/qfct_checker.sv =====
// Port-level checker for the flow-control credit tracker and its bind.
`timescale 1ns / 1ps

module qfct_checker #(
  parameter int COUNT_BITS = qfct_pkg::COUNT_BITS_DEF,
  localparam int OUT_BITS  = ((2 * COUNT_BITS + 7) / 8) * 8
) (
  input logic                clk,
  input logic                rst,
  input logic                s_tready,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [OUT_BITS-1:0] m_tdata,
  input logic                m_tuser
);

  // No result beat is offered right after reset.
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result offered after reset");

  // A stalled result beat holds its payload.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result beat changed");

  // A proposed limit is only given with the accepted flag set.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[COUNT_BITS +: COUNT_BITS] != '0 |-> m_tuser)
    else $error("limit proposed without accepted flag");

  // The input side never stalls while the result register is empty.
  assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty result register");

endmodule

bind quic_flow_credit_tracker qfct_checker #(
  .COUNT_BITS(COUNT_BITS)
) u_qfct_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// ===== sim/tb_quic_flow_credit_tracker.sv =====
// Self-checking testbench for the flow-control credit tracker.
`timescale 1ns / 1ps

// The bench drives event beats into the tracker from a backlog queue and
// checks every result beat against a predictor that keeps its own copy of
// the credit record. Events are predicted at the clock edge where the input
// beat is taken, so the predicted record follows the block beat for beat.
// Each result beat is compared field by field against the oldest pending
// prediction.
//
// The run starts with a short directed sequence under the reset settings:
// events before any init, consume saturation, blocked reporting once per
// limit, old and out-of-range offsets, window doubling and update proposals.
// After it come several random phases. Each phase writes both configuration
// registers while the block is idle and then opens with an init. The
// settings include all-zero, all-ones, a ceiling below the start credit and
// a ceiling just above it, so that the window cap is reached. Both sides
// idle in random bursts, except in the last phase. In one phase the result
// side holds off for a long stretch so the block fills and stalls its input.
module tb_quic_flow_credit_tracker;

  localparam int CB       = qfct_pkg::COUNT_BITS_DEF;
  localparam int TB       = qfct_pkg::TIME_BITS_DEF;
  localparam int IN_BITS  = ((CB + 2 * TB + 7) / 8) * 8;
  localparam int OUT_BITS = ((2 * CB + 7) / 8) * 8;
  localparam logic [CB-1:0] COUNT_MAX = '1;
  localparam logic [TB-1:0] TIME_MAX  = '1;
  localparam int PHASE_EVENTS = 125;
  localparam int HOLD_CYCLES  = 80;

  typedef struct packed {
    qfct_pkg::func_t func;
    logic [CB-1:0]   amount;
    logic [TB-1:0]   rtt_us;
    logic [TB-1:0]   drain_us;
  } flow_event_t;

  typedef struct packed {
    logic            accepted;
    logic [CB-1:0]   credit_left;
    logic [CB-1:0]   advertise;
  } credit_result_t;

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                cfg_valid = 1'b0;
  logic                                cfg_ready;
  logic [qfct_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CB-1:0]                       cfg_data = '0;
  logic                                s_tvalid = 1'b0;
  logic                                s_tready;
  logic [IN_BITS-1:0]                  s_tdata = '0;
  logic [qfct_pkg::FUNC_BITS-1:0]      s_tuser = '0;
  logic                                m_tvalid;
  logic                                m_tready = 1'b0;
  logic [OUT_BITS-1:0]                 m_tdata;
  logic                                m_tuser;

  quic_flow_credit_tracker #(
    .COUNT_BITS(CB),
    .TIME_BITS (TB)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // Stimulus and scoreboard storage.
  flow_event_t    event_backlog[$];
  credit_result_t pending_credit_results[$];

  // Shadow copy of the configuration registers, updated on each write beat.
  logic [CB-1:0] shadow_start   = qfct_pkg::START_CREDIT_RST[CB-1:0];
  logic [CB-1:0] shadow_ceiling = qfct_pkg::WINDOW_CEILING_RST[CB-1:0];

  // Predicted credit record.
  logic [CB-1:0] fc_limit       = '0;
  logic [CB-1:0] fc_used        = '0;
  logic [CB-1:0] fc_window      = '0;
  logic          fc_stalled     = 1'b0;
  logic [CB-1:0] fc_stall_limit = '0;
  logic [CB-1:0] fc_ceiling     = '0;

  // Handshake bookkeeping between the edge-sampling and the driving blocks.
  bit beat_taken;
  bit idle_on;
  bit hold_request;
  int send_gap;
  int recv_gap;
  int hold_left;

  // Run statistics.
  int mismatches;
  int results_checked;
  int events_taken;
  int input_stall_cycles;
  int settings_used;
  int func_hits[8];
  logic [CB-1:0] amount_base;

  initial begin
    forever #10 clk = ~clk;
  end

  // Generous fixed limit on the whole run.
  initial begin
    #4_000_000;
    $display("Timeout: %0d events taken, %0d results checked", events_taken,
             results_checked);
    $display("FAIL");
    $finish;
  end

  function automatic logic [CB-1:0] add_clamped(logic [CB-1:0] a, logic [CB-1:0] b);
    logic [CB:0] total;
    total = {1'b0, a} + {1'b0, b};
    return total[CB] ? COUNT_MAX : total[CB-1:0];
  endfunction

  function automatic logic [CB-1:0] credit_headroom();
    return (fc_limit > fc_used) ? fc_limit - fc_used : '0;
  endfunction

  // Applies one event to the predicted record and returns its result beat.
  function automatic credit_result_t flow_credit_step(flow_event_t ev);
    credit_result_t r;
    logic [CB-1:0]  proposal;
    r = '0;
    case (ev.func)
      qfct_pkg::FUNC_INIT: begin
        fc_limit       = shadow_start;
        fc_used        = '0;
        fc_window      = shadow_start;
        fc_stalled     = 1'b0;
        fc_stall_limit = '0;
        fc_ceiling     = (shadow_ceiling < shadow_start) ? shadow_start : shadow_ceiling;
      end
      qfct_pkg::FUNC_CONSUME: fc_used = add_clamped(fc_used, ev.amount);
      qfct_pkg::FUNC_RAISE_LIMIT: begin
        if (ev.amount > fc_limit) begin
          fc_limit   = ev.amount;
          fc_stalled = 1'b0;
          r.accepted = 1'b1;
        end
      end
      qfct_pkg::FUNC_CHECK_BLOCK: begin
        // Blocked is told once for each limit value.
        if (credit_headroom() == '0 && !(fc_stalled && fc_stall_limit == fc_limit)) begin
          fc_stalled     = 1'b1;
          fc_stall_limit = fc_limit;
          r.accepted     = 1'b1;
        end
      end
      qfct_pkg::FUNC_RECORD_OFS: begin
        if (ev.amount <= fc_used) begin
          r.accepted = 1'b1;
        end else if (ev.amount <= fc_limit) begin
          fc_used    = ev.amount;
          r.accepted = 1'b1;
        end
      end
      qfct_pkg::FUNC_APP_READ: begin
        // The window doubles when the peer drained it in under two round trips.
        if (ev.rtt_us != '0 && ev.drain_us != '0 && fc_window < fc_ceiling &&
            {1'b0, ev.drain_us} < {ev.rtt_us, 1'b0}) begin
          fc_window = (fc_window > fc_ceiling - fc_window) ? fc_ceiling : fc_window << 1;
        end
      end
      qfct_pkg::FUNC_CHECK_UPDATE: begin
        if (credit_headroom() <= (fc_window >> 1)) begin
          proposal = add_clamped(fc_used, fc_window);
          if (proposal > fc_limit) begin
            r.accepted  = 1'b1;
            r.advertise = proposal;
          end
        end
      end
      default: begin
        if (ev.amount > fc_limit) fc_limit = ev.amount;
      end
    endcase
    r.credit_left = credit_headroom();
    return r;
  endfunction

  task automatic note_mismatch(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    mismatches++;
    $display("%0t ns: mismatch on %s, expected %0h, got %0h", $time, what, want, got);
  endtask

  // Byte counts: edge values, small counts, and values around the start credit.
  function automatic logic [CB-1:0] rand_count();
    logic [63:0]   wide;
    logic [CB-1:0] span;
    logic [CB-1:0] low_end;
    wide = {$urandom, $urandom};
    span = (amount_base >> 1) + 64;
    if (span > CB'(1 << 20)) span = CB'(1 << 20);
    case ($urandom_range(0, 19))
      0:        return '0;
      1:        return COUNT_MAX;
      2, 3:     return wide[CB-1:0];
      4:        return COUNT_MAX - $urandom_range(0, 3);
      5, 6, 7, 8, 9, 10: return CB'($urandom_range(0, 4096));
      default: begin
        if (amount_base > COUNT_MAX - 2 * span) low_end = COUNT_MAX - 2 * span;
        else if (amount_base > span) low_end = amount_base - span;
        else low_end = '0;
        return low_end + CB'($urandom_range(0, 32'(2 * span)));
      end
    endcase
  endfunction

  function automatic flow_event_t random_event();
    flow_event_t ev;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick < 4)       ev.func = qfct_pkg::FUNC_INIT;
    else if (pick < 24) ev.func = qfct_pkg::FUNC_CONSUME;
    else if (pick < 34) ev.func = qfct_pkg::FUNC_RAISE_LIMIT;
    else if (pick < 46) ev.func = qfct_pkg::FUNC_CHECK_BLOCK;
    else if (pick < 60) ev.func = qfct_pkg::FUNC_RECORD_OFS;
    else if (pick < 75) ev.func = qfct_pkg::FUNC_APP_READ;
    else if (pick < 90) ev.func = qfct_pkg::FUNC_CHECK_UPDATE;
    else                ev.func = qfct_pkg::FUNC_UPDATE_SENT;
    ev.amount = rand_count();
    case ($urandom_range(0, 9))
      0: begin ev.rtt_us = '0; ev.drain_us = $urandom_range(0, 3000); end
      1: begin ev.rtt_us = $urandom_range(0, 3000); ev.drain_us = '0; end
      2: begin ev.rtt_us = $urandom; ev.drain_us = $urandom; end
      3: begin ev.rtt_us = TIME_MAX; ev.drain_us = TIME_MAX - $urandom_range(0, 1); end
      default: begin
        ev.rtt_us   = $urandom_range(1, 2000);
        ev.drain_us = $urandom_range(1, 5000);
      end
    endcase
    return ev;
  endfunction

  function automatic flow_event_t make_event(qfct_pkg::func_t f, logic [CB-1:0] amt,
                                             logic [TB-1:0] rtt, logic [TB-1:0] drain);
    flow_event_t ev;
    ev.func     = f;
    ev.amount   = amt;
    ev.rtt_us   = rtt;
    ev.drain_us = drain;
    return ev;
  endfunction

  task automatic write_reg(input logic [qfct_pkg::CFG_INDEX_BITS-1:0] idx,
                           input logic [CB-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Waits until every queued event went in and every result came back.
  task automatic wait_drained();
    while (event_backlog.size() != 0 || s_tvalid || pending_credit_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic run_phase(input logic [CB-1:0] start, input logic [CB-1:0] ceiling,
                           input bit with_idle, input bit with_hold);
    write_reg(qfct_pkg::REG_START_CREDIT, start);
    write_reg(qfct_pkg::REG_WINDOW_CEILING, ceiling);
    settings_used++;
    idle_on     = with_idle;
    amount_base = start;
    event_backlog.push_back(make_event(qfct_pkg::FUNC_INIT, '0, '0, '0));
    repeat (PHASE_EVENTS - 1) event_backlog.push_back(random_event());
    if (with_hold) hold_request = 1'b1;
    wait_drained();
  endtask

  // Sender: presents the next queued event once the current beat is taken.
  always @(negedge clk) begin
    flow_event_t ev;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || beat_taken) begin
      if (send_gap > 0) begin
        send_gap--;
        s_tvalid <= 1'b0;
      end else if (event_backlog.size() == 0) begin
        s_tvalid <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        send_gap = $urandom_range(0, 6);
        s_tvalid <= 1'b0;
      end else begin
        ev = event_backlog.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_BITS - CB - 2 * TB){1'b0}}, ev.drain_us, ev.rtt_us, ev.amount};
        s_tuser  <= ev.func;
      end
    end
    beat_taken = 1'b0;
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = HOLD_CYCLES - 1;
      m_tready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      m_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      recv_gap = $urandom_range(0, 6);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Input beats and configuration beats feed the predictor.
  always @(posedge clk) begin
    flow_event_t ev;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          qfct_pkg::REG_START_CREDIT:   shadow_start   = cfg_data;
          qfct_pkg::REG_WINDOW_CEILING: shadow_ceiling = cfg_data;
          default: ;
        endcase
      end
      if (hold_left > 0 && s_tvalid && !s_tready) input_stall_cycles++;
      if (s_tvalid && s_tready) begin
        ev.func     = qfct_pkg::func_t'(s_tuser);
        ev.amount   = s_tdata[CB-1:0];
        ev.rtt_us   = s_tdata[CB+TB-1:CB];
        ev.drain_us = s_tdata[CB+2*TB-1:CB+TB];
        pending_credit_results.push_back(flow_credit_step(ev));
        func_hits[s_tuser]++;
        events_taken++;
        beat_taken = 1'b1;
      end
    end
  end

  // Result beats are checked against the oldest prediction.
  always @(posedge clk) begin
    credit_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_credit_results.size() == 0) begin
        note_mismatch("result beat with nothing pending", '0, 64'(m_tdata[CB-1:0]));
      end else begin
        want = pending_credit_results.pop_front();
        results_checked++;
        if (m_tuser !== want.accepted)
          note_mismatch("accepted", 64'(want.accepted), 64'(m_tuser));
        if (m_tdata[CB-1:0] !== want.credit_left)
          note_mismatch("credit_left", 64'(want.credit_left), 64'(m_tdata[CB-1:0]));
        if (m_tdata[2*CB-1:CB] !== want.advertise)
          note_mismatch("advertise_limit", 64'(want.advertise), 64'(m_tdata[2*CB-1:CB]));
      end
    end
  end

  initial begin
    logic [63:0] wide;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part under the reset settings: start credit 65536.
    idle_on = 1'b1;
    // Before any init the record is all zero: blocked once, old offset valid.
    event_backlog.push_back(make_event(qfct_pkg::FUNC_CHECK_BLOCK, '0, '0, '0));
    event_backlog.push_back(make_event(qfct_pkg::FUNC_CHECK_BLOCK, '0, '0, '0));
    event_backlog.push_back(make_event(qfct_pkg::FUNC_CHECK_UPDATE, '0, '0, '0));
    event_backlog.push_back(make_event(qfct_pkg::FUNC_RECORD_OFS, '0, '0, '0));
    event_backlog.push_back(make_event(qfct_pkg::FUNC_INIT, '0, '0, '0));
    event_backlog.push_back(make_event(qfct_pkg::FUNC_CONSUME, 1000, '0, '0));
    // An offset inside the limit moves the used count, one beyond is refused.
    event_backlog.push_back(make_event(qfct_pkg::FUNC_RECORD_OFS, 5000, '0, '0));
    event_backlog.push_back(make_event(qfct_pkg::FUNC_RECORD_OFS, 70000, '0, '0));
    // Too much credit left for a proposal, then enough used to get one.
    event_backlog.push_back(make_event(qfct_pkg::FUNC_CHECK_UPDATE, '0, '0, '0));
    event_backlog.push_back(make_event(qfct_pkg::FUNC_CONSUME, 40000, '0, '0));
    event_backlog.push_back(make_event(qfct_pkg::FUNC_CHECK_UPDATE, '0, '0, '0));
    event_backlog.push_back(make_event(qfct_pkg::FUNC_UPDATE_SENT, 110536, '0, '0));
    // Window tuning: zero time does nothing, fast drain doubles, slow does not.
    event_backlog.push_back(make_event(qfct_pkg::FUNC_APP_READ, '0, '0, 5));
    event_backlog.push_back(make_event(qfct_pkg::FUNC_APP_READ, '0, 100, 150));
    event_backlog.push_back(make_event(qfct_pkg::FUNC_APP_READ, '0, 100, 200));
    // A limit that is not higher is ignored.
    event_backlog.push_back(make_event(qfct_pkg::FUNC_RAISE_LIMIT, 100, '0, '0));
    event_backlog.push_back(make_event(qfct_pkg::FUNC_RAISE_LIMIT, 200000, '0, '0));
    // The used count saturates, blocked is told once, then again after a raise.
    event_backlog.push_back(make_event(qfct_pkg::FUNC_CONSUME, COUNT_MAX, TIME_MAX, TIME_MAX));
    event_backlog.push_back(make_event(qfct_pkg::FUNC_CHECK_BLOCK, '0, '0, '0));
    event_backlog.push_back(make_event(qfct_pkg::FUNC_CHECK_BLOCK, '0, '0, '0));
    event_backlog.push_back(make_event(qfct_pkg::FUNC_RAISE_LIMIT, COUNT_MAX, '0, '0));
    event_backlog.push_back(make_event(qfct_pkg::FUNC_CHECK_BLOCK, '0, '0, '0));
    // The proposal saturates and so is no higher than the all-ones limit.
    event_backlog.push_back(make_event(qfct_pkg::FUNC_CHECK_UPDATE, '0, '0, '0));
    event_backlog.push_back(make_event(qfct_pkg::FUNC_RECORD_OFS, COUNT_MAX, '0, '0));
    event_backlog.push_back(make_event(qfct_pkg::FUNC_APP_READ, COUNT_MAX, TIME_MAX,
                                       TIME_MAX - 1));
    wait_drained();

    // Random phases, each under its own register settings. The first one
    // also carries the long receiver hold-off.
    wide = {$urandom, $urandom};
    run_phase(CB'($urandom_range(2000, 100000)), CB'($urandom_range(100000, 2000000)),
              1'b1, 1'b1);
    run_phase('0, '0, 1'b1, 1'b0);
    run_phase(COUNT_MAX, COUNT_MAX, 1'b1, 1'b0);
    run_phase(wide[CB-1:0], '0, 1'b1, 1'b0);
    // A ceiling just above the start credit makes the doubling hit the cap.
    run_phase(1000, 1500, 1'b1, 1'b0);
    // Last phase runs back to back with no idling on either side.
    run_phase(CB'($urandom_range(1, 50000)), COUNT_MAX, 1'b0, 1'b0);

    repeat (8) @(posedge clk);
    if (pending_credit_results.size() != 0)
      note_mismatch("results still pending at the end", '0,
                    64'(pending_credit_results.size()));

    $display("Covered %0d events over %0d register settings: init %0d, consume %0d,",
             events_taken, settings_used + 1, func_hits[qfct_pkg::FUNC_INIT],
             func_hits[qfct_pkg::FUNC_CONSUME]);
    $display("  raise %0d, blocked %0d, offset %0d, read %0d, update %0d/%0d;",
             func_hits[qfct_pkg::FUNC_RAISE_LIMIT], func_hits[qfct_pkg::FUNC_CHECK_BLOCK],
             func_hits[qfct_pkg::FUNC_RECORD_OFS], func_hits[qfct_pkg::FUNC_APP_READ],
             func_hits[qfct_pkg::FUNC_CHECK_UPDATE], func_hits[qfct_pkg::FUNC_UPDATE_SENT]);
    $display("  %0d results checked, %0d input stall cycles", results_checked,
             input_stall_cycles);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/qfct_pkg.sv
design/quic_flow_credit_tracker.sv
design/qfct_checker.sv
sim/tb_quic_flow_credit_tracker.sv
